[rtl/pslg_pkg.sv]
// ----------------------------------------------------------------------------
// pslg_pkg
// Shared constants, register indexes and the log2 fraction table of the
// log-gain PID speed controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pslg_pkg;

   localparam int SIG_W   = 24;   // Q15.8 signal
   localparam int ERR_W   = 25;   // Q16.8 error
   localparam int LIM_W   = 23;   // clamp and threshold registers
   localparam int GAIN_W  = 24;   // Q8.16 gains
   localparam int SEP_W   = 16;
   localparam int CSR_W   = 24;
   localparam int IDX_W   = 3;
   localparam int MC_W    = 52;   // serial multiplier multiplicand / accumulator
   localparam int MP_W    = 26;   // serial multiplier multiplier

   localparam logic [MP_W-1:0] KP_LOG_SCALE = 26'd98642;
   localparam logic [MP_W-1:0] ARG_MUL      = 26'd53;
   localparam logic [ERR_W:0]  ARG_OFFSET   = 26'd2560;
   localparam logic [30:0]     ONE_Q8       = 31'd256;

   localparam logic [IDX_W-1:0] REG_MAX_OUTPUT     = 3'd0;
   localparam logic [IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd1;
   localparam logic [IDX_W-1:0] REG_DEADBAND       = 3'd2;
   localparam logic [IDX_W-1:0] REG_MAX_ERROR      = 3'd3;
   localparam logic [IDX_W-1:0] REG_INTEGRAL_GAIN  = 3'd4;
   localparam logic [IDX_W-1:0] REG_DERIV_GAIN     = 3'd5;
   localparam logic [IDX_W-1:0] REG_SEPARATION     = 3'd6;
   localparam logic [IDX_W-1:0] REG_MIN_SETPOINT   = 3'd7;

   // log2(1 + i/32) in Q16
   function automatic logic [16:0] log2_frac(input logic [5:0] idx);
      logic [16:0] v;
      case (idx)
         6'd0:  v = 17'd0;
         6'd1:  v = 17'd2909;
         6'd2:  v = 17'd5732;
         6'd3:  v = 17'd8473;
         6'd4:  v = 17'd11136;
         6'd5:  v = 17'd13727;
         6'd6:  v = 17'd16248;
         6'd7:  v = 17'd18704;
         6'd8:  v = 17'd21098;
         6'd9:  v = 17'd23433;
         6'd10: v = 17'd25711;
         6'd11: v = 17'd27936;
         6'd12: v = 17'd30109;
         6'd13: v = 17'd32234;
         6'd14: v = 17'd34312;
         6'd15: v = 17'd36346;
         6'd16: v = 17'd38336;
         6'd17: v = 17'd40286;
         6'd18: v = 17'd42196;
         6'd19: v = 17'd44068;
         6'd20: v = 17'd45904;
         6'd21: v = 17'd47705;
         6'd22: v = 17'd49472;
         6'd23: v = 17'd51207;
         6'd24: v = 17'd52911;
         6'd25: v = 17'd54584;
         6'd26: v = 17'd56229;
         6'd27: v = 17'd57845;
         6'd28: v = 17'd59434;
         6'd29: v = 17'd60997;
         6'd30: v = 17'd62534;
         6'd31: v = 17'd64047;
         6'd32: v = 17'd65536;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

[rtl/pid_speed_controller_log_gain.sv]
// ----------------------------------------------------------------------------
// pid_speed_controller_log_gain
// Positional PID with log-shaped proportional gain, deadband, error gate,
// integral separation and symmetric clamps. One shift-add multiplier,
// one multiplier bit per cycle, is shared by all products.
// ----------------------------------------------------------------------------
// flow: gated beats go from S_CHECK straight to S_OUT; others pass through the
//   bit-serial multiplier passes (XMUL, DRMUL, LMUL, PMUL, IMUL, DMUL, the
//   integral pass skipped when the integral is cleared) and the msb search;
//   a result waiting on rsp_tready holds the next one in S_OUT
// throughput: one beat at a time, next beat accepted after S_OUT registers the result
// reset: synchronous, clears control, registers to defaults, previous error and integral
`default_nettype none

module pid_speed_controller_log_gain (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // measured [23:0], target [47:24]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // drive [23:0]
   output logic             rsp_tuser,   // gated [0]
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_wdata
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CHECK  = 4'd1;
   localparam logic [3:0] S_XMUL   = 4'd2;
   localparam logic [3:0] S_NORM   = 4'd3;
   localparam logic [3:0] S_DRMUL  = 4'd4;
   localparam logic [3:0] S_LMUL   = 4'd5;
   localparam logic [3:0] S_PMUL   = 4'd6;
   localparam logic [3:0] S_IMUL   = 4'd7;
   localparam logic [3:0] S_DSTART = 4'd8;
   localparam logic [3:0] S_DMUL   = 4'd9;
   localparam logic [3:0] S_OUT    = 4'd10;

   localparam int MC_W = pslg_pkg::MC_W;
   localparam int MP_W = pslg_pkg::MP_W;

   // configuration
   logic [22:0] max_out_ff, ilim_ff, deadband_ff, max_err_ff, min_sp_ff;
   logic [23:0] ki_ff, kd_ff;
   logic [15:0] sep_ff;

   logic [3:0]  state_ff, state_in;
   logic [24:0] err_ff, err_in, last_ff, last_in, isum_ff, isum_in;
   logic [23:0] tgt_ff, tgt_in;
   logic        clr_ff, clr_in;
   logic [30:0] norm_ff, norm_in;
   logic [4:0]  p_ff, p_in;
   logic [4:0]  idx_ff, idx_in;
   logic signed [31:0] pout_ff, pout_in;
   logic        dneg_ff, dneg_in;
   logic [MC_W-1:0] mc_ff, mc_in, acc_ff, acc_in;
   logic [MP_W-1:0] mp_ff, mp_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [23:0] res_drive_ff, res_drive_in;
   logic        res_gated_ff, res_gated_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_drive_ff, rsp_drive_in;
   logic        rsp_gated_ff, rsp_gated_in;

   logic [24:0] aerr;
   logic [25:0] eofs, eofs_mag, derr, derr_mag;
   logic [23:0] atgt;
   logic [30:0] xval;
   logic [16:0] tab_lo;
   logic [21:0] lval;
   logic [MC_W-1:0] rnd;
   logic [35:0] rmag;
   logic signed [35:0] isum_new, ilim_s;
   logic signed [37:0] total, dout_s, olim_s;
   logic        gate, busy_mul;

   assign aerr     = err_ff[24] ? (25'd0 - err_ff) : err_ff;
   assign atgt     = tgt_ff[23] ? (24'd0 - tgt_ff) : tgt_ff;
   assign eofs     = {err_ff[24], err_ff} + pslg_pkg::ARG_OFFSET;
   assign eofs_mag = eofs[25] ? (26'd0 - eofs) : eofs;
   assign derr     = {err_ff[24], err_ff} - {last_ff[24], last_ff};
   assign derr_mag = derr[25] ? (26'd0 - derr) : derr;
   assign xval     = (acc_ff[30:0] < pslg_pkg::ONE_Q8) ? pslg_pkg::ONE_Q8 : acc_ff[30:0];
   assign tab_lo   = pslg_pkg::log2_frac({1'b0, idx_ff});
   assign lval     = {1'b0, p_ff - 5'd8, 16'd0} + {5'd0, tab_lo} + {5'd0, acc_ff[32:16]};
   assign rnd      = acc_ff + MC_W'(32768);
   assign rmag     = rnd[MC_W-1:16];
   assign gate     = ((max_err_ff != 23'd0) && (aerr > {2'b0, max_err_ff})) ||
                     ((deadband_ff != 23'd0) && (aerr < {2'b0, deadband_ff}));
   assign ilim_s   = $signed({13'd0, ilim_ff});
   assign olim_s   = $signed({15'd0, max_out_ff});
   assign busy_mul = (state_ff == S_XMUL) || (state_ff == S_DRMUL) ||
                     (state_ff == S_LMUL) || (state_ff == S_PMUL) ||
                     (state_ff == S_IMUL) || (state_ff == S_DMUL);

   always_comb begin
      isum_new = $signed({{11{isum_ff[24]}}, isum_ff}) +
                 (err_ff[24] ? -$signed({1'b0, rmag[34:0]}) : $signed({1'b0, rmag[34:0]}));
      dout_s   = dneg_ff ? -$signed({2'b0, rmag}) : $signed({2'b0, rmag});
      total    = $signed({{6{pout_ff[31]}}, pout_ff}) +
                 $signed({{13{isum_ff[24]}}, isum_ff}) + dout_s;
   end

   always_comb begin
      state_in     = state_ff;
      err_in       = err_ff;
      tgt_in       = tgt_ff;
      last_in      = last_ff;
      isum_in      = isum_ff;
      clr_in       = clr_ff;
      norm_in      = norm_ff;
      p_in         = p_ff;
      idx_in       = idx_ff;
      pout_in      = pout_ff;
      dneg_in      = dneg_ff;
      mc_in        = mc_ff;
      mp_in        = mp_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      res_drive_in = res_drive_ff;
      res_gated_in = res_gated_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_drive_in = rsp_drive_ff;
      rsp_gated_in = rsp_gated_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // one multiplier bit per cycle
      if (busy_mul && (cnt_ff != 5'd0)) begin
         acc_in = acc_ff + (mp_ff[0] ? mc_ff : '0);
         mc_in  = {mc_ff[MC_W-2:0], 1'b0};
         mp_in  = {1'b0, mp_ff[MP_W-1:1]};
         cnt_in = cnt_ff - 5'd1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               err_in   = {req_tdata[47], req_tdata[47:24]} - {req_tdata[23], req_tdata[23:0]};
               tgt_in   = req_tdata[47:24];
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (gate) begin
               res_drive_in = 24'd0;
               res_gated_in = 1'b1;
               state_in     = S_OUT;
            end else begin
               clr_in   = ((sep_ff != 16'd0) && (aerr > {1'b0, sep_ff, 8'd0})) ||
                          (atgt < {1'b0, min_sp_ff});
               mc_in    = {26'd0, eofs_mag};
               mp_in    = pslg_pkg::ARG_MUL;
               acc_in   = '0;
               cnt_in   = 5'd6;
               state_in = S_XMUL;
            end
         end
         S_XMUL: begin
            if (cnt_ff == 5'd0) begin
               norm_in  = xval;
               p_in     = 5'd30;
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            // msb search, one position a cycle
            if (norm_ff[30]) begin
               idx_in   = norm_ff[29:25];
               mc_in    = MC_W'(pslg_pkg::log2_frac({1'b0, norm_ff[29:25]} + 6'd1) -
                                pslg_pkg::log2_frac({1'b0, norm_ff[29:25]}));
               mp_in    = {10'd0, norm_ff[24:9]};
               acc_in   = '0;
               cnt_in   = 5'd16;
               state_in = S_DRMUL;
            end else begin
               norm_in = {norm_ff[29:0], 1'b0};
               p_in    = p_ff - 5'd1;
            end
         end
         S_DRMUL: begin
            if (cnt_ff == 5'd0) begin
               mc_in    = {30'd0, lval};
               mp_in    = pslg_pkg::KP_LOG_SCALE;
               acc_in   = '0;
               cnt_in   = 5'd17;
               state_in = S_LMUL;
            end
         end
         S_LMUL: begin
            if (cnt_ff == 5'd0) begin
               mc_in    = {30'd0, rmag[21:0]};
               mp_in    = {1'b0, aerr};
               acc_in   = '0;
               cnt_in   = 5'd25;
               state_in = S_PMUL;
            end
         end
         S_PMUL: begin
            if (cnt_ff == 5'd0) begin
               pout_in = err_ff[24] ? -$signed({1'b0, rmag[30:0]}) : $signed({1'b0, rmag[30:0]});
               if (clr_ff) begin
                  isum_in  = 25'd0;
                  state_in = S_DSTART;
               end else begin
                  mc_in    = {28'd0, ki_ff};
                  mp_in    = {1'b0, aerr};
                  acc_in   = '0;
                  cnt_in   = 5'd25;
                  state_in = S_IMUL;
               end
            end
         end
         S_IMUL: begin
            if (cnt_ff == 5'd0) begin
               if (isum_new > ilim_s) begin
                  isum_in = {2'b0, ilim_ff};
               end else if (isum_new < -ilim_s) begin
                  isum_in = 25'd0 - {2'b0, ilim_ff};
               end else begin
                  isum_in = isum_new[24:0];
               end
               state_in = S_DSTART;
            end
         end
         S_DSTART: begin
            dneg_in  = derr[25];
            mc_in    = {28'd0, kd_ff};
            mp_in    = derr_mag;
            acc_in   = '0;
            cnt_in   = 5'd26;
            state_in = S_DMUL;
         end
         S_DMUL: begin
            if (cnt_ff == 5'd0) begin
               if (total > olim_s) begin
                  res_drive_in = {1'b0, max_out_ff};
               end else if (total < -olim_s) begin
                  res_drive_in = 24'd0 - {1'b0, max_out_ff};
               end else begin
                  res_drive_in = total[23:0];
               end
               res_gated_in = 1'b0;
               last_in      = err_ff;
               state_in     = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_drive_in = res_drive_ff;
               rsp_gated_in = res_gated_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         last_ff      <= 25'd0;
         isum_ff      <= 25'd0;
         max_out_ff   <= 23'd8388607;
         ilim_ff      <= 23'd8388607;
         deadband_ff  <= 23'd0;
         max_err_ff   <= 23'd0;
         ki_ff        <= 24'd0;
         kd_ff        <= 24'd0;
         sep_ff       <= 16'd0;
         min_sp_ff    <= 23'd38400;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
         isum_ff      <= isum_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               pslg_pkg::REG_MAX_OUTPUT:     max_out_ff  <= csr_wdata[22:0];
               pslg_pkg::REG_INTEGRAL_LIMIT: ilim_ff     <= csr_wdata[22:0];
               pslg_pkg::REG_DEADBAND:       deadband_ff <= csr_wdata[22:0];
               pslg_pkg::REG_MAX_ERROR:      max_err_ff  <= csr_wdata[22:0];
               pslg_pkg::REG_INTEGRAL_GAIN:  ki_ff       <= csr_wdata;
               pslg_pkg::REG_DERIV_GAIN:     kd_ff       <= csr_wdata;
               pslg_pkg::REG_SEPARATION:     sep_ff      <= csr_wdata[15:0];
               pslg_pkg::REG_MIN_SETPOINT:   min_sp_ff   <= csr_wdata[22:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      err_ff       <= err_in;
      tgt_ff       <= tgt_in;
      clr_ff       <= clr_in;
      norm_ff      <= norm_in;
      p_ff         <= p_in;
      idx_ff       <= idx_in;
      pout_ff      <= pout_in;
      dneg_ff      <= dneg_in;
      mc_ff        <= mc_in;
      mp_ff        <= mp_in;
      acc_ff       <= acc_in;
      cnt_ff       <= cnt_in;
      res_drive_ff <= res_drive_in;
      res_gated_ff <= res_gated_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_gated_ff <= rsp_gated_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_drive_ff;
   assign rsp_tuser  = rsp_gated_ff;

endmodule

`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the log-gain PID speed controller. A bit-exact
// predictor tracks error history and the integral. Each accepted sample
// queues one expected drive beat, which the checker compares with the DUT.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 5000;
   localparam int TAIL_CYCLES = 200;

   typedef struct packed {
      logic [23:0] drive;
      logic        gated;
   } drive_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // measured [23:0], target [47:24]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // drive [23:0]
   logic        rsp_tuser;        // gated [0]
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_wdata = '0;

   pid_speed_controller_log_gain uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // log2(1 + i/32) in Q16
   localparam longint unsigned LOG_FRAC [0:32] = '{
      0, 2909, 5732, 8473, 11136, 13727, 16248, 18704,
      21098, 23433, 25711, 27936, 30109, 32234, 34312, 36346,
      38336, 40286, 42196, 44068, 45904, 47705, 49472, 51207,
      52911, 54584, 56229, 57845, 59434, 60997, 62534, 64047,
      65536};

   logic [23:0]     ctl_regs [8];
   logic [23:0]     next_regs [8];
   longint          prev_error;
   longint          integ_sum;
   drive_beat_type  pending_drive [$];
   int              errors = 0;
   int              samples_sent = 0;
   int              beats_checked = 0;
   int              gated_seen = 0;
   int              hold_left = 0;
   int              stall_left = 0;
   bit              calm = 1'b0;
   int              idle_count = 0;

   function automatic longint unsigned mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint round_q16(longint v);
      longint m;
      m = (mag(v) + 32768) >> 16;
      return v < 0 ? -m : m;
   endfunction

   function automatic longint clamp_sym(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // proportional gain 5*log10(53*|e+10|), Q16
   function automatic longint unsigned kp_q16(longint e);
      longint unsigned x, m, l, d, r;
      int p;
      int idx;
      x = 53 * mag(e + 2560);
      if (x < 256) x = 256;
      p = 0;
      while (p < 40 && (x >> (p + 1)) != 0) p++;
      m = (x << (40 - p)) & 64'hFF_FFFF_FFFF;
      idx = int'((m >> 35) & 31);
      r = (m >> 19) & 16'hFFFF;
      d = LOG_FRAC[idx + 1] - LOG_FRAC[idx];
      l = (longint'(p - 8) << 16) + LOG_FRAC[idx] + ((d * r) >> 16);
      return (l * 98642 + 32768) >> 16;
   endfunction

   function automatic drive_beat_type predict_drive(logic [23:0] meas, logic [23:0] tgt);
      longint err, aerr, pterm, dterm, total, mtgt;
      drive_beat_type b;
      err = longint'(signed'(tgt)) - longint'(signed'(meas));
      aerr = mag(err);
      mtgt = mag(longint'(signed'(tgt)));
      if ((ctl_regs[pslg_pkg::REG_MAX_ERROR] != 0 &&
           aerr > ctl_regs[pslg_pkg::REG_MAX_ERROR]) ||
          (ctl_regs[pslg_pkg::REG_DEADBAND] != 0 &&
           aerr < ctl_regs[pslg_pkg::REG_DEADBAND])) begin
         b.drive = '0;
         b.gated = 1'b1;
         return b;
      end
      pterm = round_q16(longint'(kp_q16(err)) * err);
      if ((ctl_regs[pslg_pkg::REG_SEPARATION] != 0 &&
           aerr > (longint'(ctl_regs[pslg_pkg::REG_SEPARATION]) << 8)) ||
          mtgt < ctl_regs[pslg_pkg::REG_MIN_SETPOINT])
         integ_sum = 0;
      else
         integ_sum += round_q16(longint'(ctl_regs[pslg_pkg::REG_INTEGRAL_GAIN]) * err);
      integ_sum = clamp_sym(integ_sum, ctl_regs[pslg_pkg::REG_INTEGRAL_LIMIT]);
      dterm = round_q16(longint'(ctl_regs[pslg_pkg::REG_DERIV_GAIN]) * (err - prev_error));
      total = clamp_sym(pterm + integ_sum + dterm, ctl_regs[pslg_pkg::REG_MAX_OUTPUT]);
      prev_error = err;
      b.drive = total[23:0];
      b.gated = 1'b0;
      return b;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 4);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [23:0] rand24(int unsigned hi);
      return 24'($urandom_range(0, hi));
   endfunction

   // result side: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         stall_left = pick_gap();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      drive_beat_type exp_b;
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_checked++;
         if (rsp_tuser) gated_seen++;
         if (pending_drive.size() == 0) begin
            $error("unexpected drive beat %h gated %b", rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            exp_b = pending_drive.pop_front();
            if (rsp_tdata !== exp_b.drive) begin
               $error("drive: expected %h actual %h", exp_b.drive, rsp_tdata);
               errors++;
            end
            if (rsp_tuser !== exp_b.gated) begin
               $error("gated: expected %b actual %b", exp_b.gated, rsp_tuser);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_count <= 0;
      else if (idle_count >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else
         idle_count <= idle_count + 1;
   end

   // the tasks that wait on the clock start and end just after a falling edge
   task automatic send_sample(logic [23:0] meas, logic [23:0] tgt);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= {tgt, meas};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_drive.push_back(predict_drive(meas, tgt));
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_drive.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   task automatic program_regs();
      for (int i = 0; i < 8; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= i[2:0];
         csr_wdata <= next_regs[i];
         ctl_regs[i] = next_regs[i];
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_defaults();
      next_regs[pslg_pkg::REG_MAX_OUTPUT] = 24'h7FFFFF;
      next_regs[pslg_pkg::REG_INTEGRAL_LIMIT] = 24'h7FFFFF;
      next_regs[pslg_pkg::REG_DEADBAND] = '0;
      next_regs[pslg_pkg::REG_MAX_ERROR] = '0;
      next_regs[pslg_pkg::REG_INTEGRAL_GAIN] = '0;
      next_regs[pslg_pkg::REG_DERIV_GAIN] = '0;
      next_regs[pslg_pkg::REG_SEPARATION] = '0;
      next_regs[pslg_pkg::REG_MIN_SETPOINT] = 24'd38400;
   endtask

   task automatic test_reset_defaults();
      send_sample(24'h000000, 24'h000000);
      send_sample(24'h800000, 24'h7FFFFF);   // largest positive error
      send_sample(24'h7FFFFF, 24'h800000);   // largest negative error
      send_sample(24'h000A00, 24'h000000);   // err = -10.0, log arg below one
      send_sample(24'h000000, 24'h009500);   // target just under min setpoint
      send_sample(24'h001000, 24'h009600);
      drain();
   endtask

   task automatic test_gates_and_gains();
      load_defaults();
      next_regs[pslg_pkg::REG_DEADBAND] = 24'h000400;
      next_regs[pslg_pkg::REG_MAX_ERROR] = 24'h010000;
      next_regs[pslg_pkg::REG_INTEGRAL_GAIN] = 24'hFFFFFF;
      next_regs[pslg_pkg::REG_DERIV_GAIN] = 24'hFFFFFF;
      next_regs[pslg_pkg::REG_SEPARATION] = 24'h000080;
      next_regs[pslg_pkg::REG_MIN_SETPOINT] = '0;
      program_regs();
      send_sample(24'h010000, 24'h010100);   // inside deadband
      send_sample(24'h010000, 24'h010400);   // on the deadband edge
      send_sample(24'h000000, 24'h010000);   // on the max error edge
      send_sample(24'h000000, 24'h010001);   // beyond max error
      send_sample(24'h000000, 24'h008001);   // beyond separation
      send_sample(24'h000000, 24'h008000);
      send_sample(24'h002000, 24'h000000);
      drain();
      next_regs[pslg_pkg::REG_DEADBAND] = '0;
      next_regs[pslg_pkg::REG_MAX_ERROR] = '0;
      next_regs[pslg_pkg::REG_SEPARATION] = 24'h00FFFF;
      next_regs[pslg_pkg::REG_MAX_OUTPUT] = '0;
      next_regs[pslg_pkg::REG_INTEGRAL_LIMIT] = '0;
      program_regs();
      send_sample(24'h800000, 24'h7FFFFF);
      send_sample(24'h7FFFFF, 24'h800000);
      drain();
      next_regs[pslg_pkg::REG_MAX_OUTPUT] = 24'h7FFFFF;
      next_regs[pslg_pkg::REG_INTEGRAL_LIMIT] = 24'h001000;
      next_regs[pslg_pkg::REG_MIN_SETPOINT] = 24'h7FFFFF;
      program_regs();
      send_sample(24'h800000, 24'h7FFFFF);
      send_sample(24'h123456, 24'h7FFFFF);
      send_sample(24'h000000, 24'h800000);
      drain();
   endtask

   task automatic test_backpressure();
      load_defaults();
      next_regs[pslg_pkg::REG_INTEGRAL_GAIN] = 24'h000800;
      next_regs[pslg_pkg::REG_DERIV_GAIN] = 24'h004000;
      program_regs();
      hold_left = 400;
      for (int i = 0; i < 6; i++)
         send_sample(rand24(24'hFFFFFF), rand24(24'hFFFFFF));
      drain();
   endtask

   task automatic randomize_regs();
      for (int i = 0; i < 8; i++) begin
         case ($urandom_range(0, 5))
            0: next_regs[i] = '0;
            1: next_regs[i] = rand24(24'hFFF);
            2: next_regs[i] = rand24(24'hFFFF);
            default: next_regs[i] = rand24(24'hFFFFFF);
         endcase
      end
      for (int i = 0; i < 8; i++) begin
         if (i == pslg_pkg::REG_SEPARATION) next_regs[i] &= 24'h00FFFF;
         else if (i != pslg_pkg::REG_INTEGRAL_GAIN && i != pslg_pkg::REG_DERIV_GAIN)
            next_regs[i] &= 24'h7FFFFF;
      end
      // keep the gates from swallowing most samples
      if ($urandom_range(0, 2) != 0) next_regs[pslg_pkg::REG_MAX_ERROR] = '0;
      if ($urandom_range(0, 2) != 0) next_regs[pslg_pkg::REG_DEADBAND] &= 24'h0003FF;
      if ($urandom_range(0, 1) == 0) next_regs[pslg_pkg::REG_MIN_SETPOINT] &= 24'h00FFFF;
      if ($urandom_range(0, 3) == 0) next_regs[pslg_pkg::REG_MAX_OUTPUT] = 24'h7FFFFF;
   endtask

   task automatic test_random_phases();
      logic [23:0] meas, tgt;
      for (int ph = 0; ph < 10; ph++) begin
         randomize_regs();
         program_regs();
         calm = (ph % 4 == 3);
         for (int i = 0; i < 100; i++) begin
            tgt = rand24(24'hFFFFFF);
            case ($urandom_range(0, 9))
               0, 1, 2: meas = rand24(24'hFFFFFF);
               3:       meas = tgt ^ 24'h800000;
               default: meas = tgt + rand24(8000) - 24'd4000;
            endcase
            if ($urandom_range(0, 15) == 0)
               tgt = ($urandom_range(0, 1) != 0) ? 24'h7FFFFF : 24'h800000;
            send_sample(meas, tgt);
         end
         drain();
      end
      calm = 1'b0;
   endtask

   initial begin
      load_defaults();
      for (int i = 0; i < 8; i++) ctl_regs[i] = next_regs[i];
      prev_error = 0;
      integ_sum = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_defaults();
      test_gates_and_gains();
      test_backpressure();
      test_random_phases();
      $display("covered %0d samples, %0d drive beats checked (%0d gated)",
               samples_sent, beats_checked, gated_seen);
      $display("register sweeps included clamp extremes, gates and a long output hold-off");
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
